// ===== hdl/rit_pkg.sv =====
// ----------------------------------------------------------------------------
// rit_pkg
// Shared types and constants of the raster-to-toolpath block: register map,
// command kinds, command step order and the configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package rit_pkg;

  // Default largest image dimension
  localparam int MAX_DIM_DEF     = 4096;
  // Default depth of the request queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;
  // A pixel whose channel sum exceeds this is light
  localparam int LIGHT_LIMIT     = 381;

  // Configuration register map (word index)
  typedef enum logic [2:0] {
    REG_LAST_COLUMN   = 3'd0,
    REG_LAST_ROW      = 3'd1,
    REG_Z_DOWN        = 3'd2,
    REG_Z_UP          = 3'd3,
    REG_FILL_STEP     = 3'd4,
    REG_MAIN_AXIS_X   = 3'd5,
    REG_REVERSE_LINES = 3'd6,
    REG_SERPENTINE    = 3'd7
  } reg_idx_t;

  // Output command kinds
  typedef enum logic [1:0] {
    CMD_MOVE_X = 2'd0,
    CMD_MOVE_Y = 2'd1,
    CMD_MOVE_Z = 2'd2,
    CMD_HOME   = 2'd3
  } cmd_kind_t;

  // Command steps of one pixel, in emission order
  localparam int STEP_HDR_Z = 0;
  localparam int STEP_HOME  = 1;
  localparam int STEP_CROSS = 2;
  localparam int STEP_START = 3;
  localparam int STEP_ZDN   = 4;
  localparam int STEP_END   = 5;
  localparam int STEP_ZUP   = 6;
  localparam int NUM_STEPS  = 7;

  typedef logic [NUM_STEPS-1:0] step_mask_t;

  // Configuration register bundle
  typedef struct packed {
    logic [11:0] last_column;
    logic [11:0] last_row;
    logic [15:0] z_down;
    logic [15:0] z_up;
    logic [11:0] fill_step;
    logic        main_axis_x;
    logic        reverse_lines;
    logic        serpentine;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hdl/rit_pixel_if.sv =====
// ----------------------------------------------------------------------------
// rit_pixel_if
// Pixel request channel: one RGB pixel per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface rit_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ===== hdl/rit_cmd_if.sv =====
// ----------------------------------------------------------------------------
// rit_cmd_if
// Machine command channel: one move, Z or home command per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface rit_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command_kind;
  logic [15:0] target;
  logic        last_of_pixel;

  modport source (output valid, output command_kind, output target,
                  output last_of_pixel, input ready);
  modport sink   (input valid, input command_kind, input target,
                  input last_of_pixel, output ready);
endinterface

`default_nettype wire

// ===== hdl/rit_cfg.sv =====
// ----------------------------------------------------------------------------
// rit_cfg
// APB-style configuration registers with read back.
// ----------------------------------------------------------------------------
`default_nettype none

module rit_cfg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready,
  output rit_pkg::cfg_t    cfg
);

  rit_pkg::cfg_t     cfg_r;
  rit_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx        = rit_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  // Hold register values, update on a write access
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.last_column   <= 12'd255;
      cfg_r.last_row      <= 12'd255;
      cfg_r.z_down        <= 16'd0;
      cfg_r.z_up          <= 16'd100;
      cfg_r.fill_step     <= 12'd1;
      cfg_r.main_axis_x   <= 1'b1;
      cfg_r.reverse_lines <= 1'b0;
      cfg_r.serpentine    <= 1'b1;
    end else if (wr_en) begin
      unique case (idx)
        rit_pkg::REG_LAST_COLUMN:   cfg_r.last_column   <= cfg_pwdata[11:0];
        rit_pkg::REG_LAST_ROW:      cfg_r.last_row      <= cfg_pwdata[11:0];
        rit_pkg::REG_Z_DOWN:        cfg_r.z_down        <= cfg_pwdata[15:0];
        rit_pkg::REG_Z_UP:          cfg_r.z_up          <= cfg_pwdata[15:0];
        rit_pkg::REG_FILL_STEP:     cfg_r.fill_step     <= cfg_pwdata[11:0];
        rit_pkg::REG_MAIN_AXIS_X:   cfg_r.main_axis_x   <= cfg_pwdata[0];
        rit_pkg::REG_REVERSE_LINES: cfg_r.reverse_lines <= cfg_pwdata[0];
        rit_pkg::REG_SERPENTINE:    cfg_r.serpentine    <= cfg_pwdata[0];
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    unique case (idx)
      rit_pkg::REG_LAST_COLUMN:   cfg_prdata = {20'd0, cfg_r.last_column};
      rit_pkg::REG_LAST_ROW:      cfg_prdata = {20'd0, cfg_r.last_row};
      rit_pkg::REG_Z_DOWN:        cfg_prdata = {16'd0, cfg_r.z_down};
      rit_pkg::REG_Z_UP:          cfg_prdata = {16'd0, cfg_r.z_up};
      rit_pkg::REG_FILL_STEP:     cfg_prdata = {20'd0, cfg_r.fill_step};
      rit_pkg::REG_MAIN_AXIS_X:   cfg_prdata = {31'd0, cfg_r.main_axis_x};
      rit_pkg::REG_REVERSE_LINES: cfg_prdata = {31'd0, cfg_r.reverse_lines};
      rit_pkg::REG_SERPENTINE:    cfg_prdata = {31'd0, cfg_r.serpentine};
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/rit_front.sv =====
// ----------------------------------------------------------------------------
// rit_front
// Pixel front end: thresholds each pixel, tracks scan position and the open
// dark run, and queues a command descriptor for each pixel that emits.
// ----------------------------------------------------------------------------
`default_nettype none

module rit_front #(
  parameter int MAX_DIM = rit_pkg::MAX_DIM_DEF,
  localparam int LW = $clog2(MAX_DIM),
  localparam int AW = LW + 2,
  localparam int NW = ((LW > 12) ? LW : 12) + 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  rit_pkg::cfg_t      cfg,
  rit_pixel_if.sink          in_px,
  input  wire logic          q_full,
  output logic               push,
  output rit_pkg::step_mask_t push_mask,
  output logic [LW-1:0]      push_line,
  output logic [AW-1:0]      push_start,
  output logic [AW-1:0]      push_end
);

  localparam logic signed [AW-1:0] A_ONE  = AW'(1);
  localparam logic signed [AW-1:0] A_NEG  = '1;
  localparam logic signed [AW-1:0] A_ZERO = '0;
  localparam logic [NW-1:0]        DIM_LIM = NW'(MAX_DIM - 1);

  // Scan state
  logic                 hdr_sent_r, hdr_sent_nxt;
  logic signed [AW-1:0] along_r, along_nxt;
  logic                 fwd_r, fwd_nxt;
  logic [LW-1:0]        line_r, line_nxt;
  logic                 run_open_r, run_open_nxt;
  logic signed [AW-1:0] run_start_r, run_start_nxt;
  logic                 lls_valid_r, lls_valid_nxt;
  logic [LW-1:0]        lls_r, lls_nxt;

  logic                 accept;
  logic [9:0]           sum;
  logic                 dark;
  logic [NW-1:0]        along_dim, line_dim;
  logic signed [AW-1:0] last_along;
  logic [LW-1:0]        last_line;
  logic [11:0]          step;
  logic                 hdr;
  logic signed [AW-1:0] along_eff, pos, start_eff, end_pos;
  logic                 fwd_eff, open_eff, lls_valid_eff;
  logic [LW-1:0]        line_eff;
  logic                 at_end, close, cross_en, end_en, done;
  logic signed [NW-1:0] line_cur, line_step, line_new, last_line_n;

  assign accept    = in_px.valid && in_px.ready;
  assign in_px.ready = !q_full;

  // Threshold and clamp the configured dimensions
  always_comb begin
    sum        = 10'(in_px.red) + 10'(in_px.green) + 10'(in_px.blue);
    dark       = sum <= 10'(rit_pkg::LIGHT_LIMIT);
    along_dim  = NW'(cfg.main_axis_x ? cfg.last_column : cfg.last_row);
    line_dim   = NW'(cfg.main_axis_x ? cfg.last_row : cfg.last_column);
    if (along_dim > DIM_LIM) along_dim = DIM_LIM;
    if (line_dim > DIM_LIM) line_dim = DIM_LIM;
    last_along = AW'(along_dim);
    last_line  = LW'(line_dim);
    step       = (cfg.fill_step == 12'd0) ? 12'd1 : cfg.fill_step;
  end

  // Classify the pixel and work out the next scan state
  always_comb begin
    hdr           = !hdr_sent_r;
    along_eff     = hdr ? A_NEG : along_r;
    fwd_eff       = hdr ? 1'b1 : fwd_r;
    open_eff      = hdr ? 1'b0 : run_open_r;
    lls_valid_eff = hdr ? 1'b0 : lls_valid_r;
    line_eff      = hdr ? (cfg.reverse_lines ? last_line : '0) : line_r;

    pos    = fwd_eff ? along_eff + A_ONE : along_eff - A_ONE;
    at_end = fwd_eff ? (pos >= last_along) : (pos <= A_ZERO);

    start_eff = (dark && !open_eff) ? pos : (hdr ? A_ZERO : run_start_r);
    close     = (open_eff && !dark) || (at_end && dark);
    cross_en  = close && !(lls_valid_eff && (lls_r == line_eff));
    end_en    = close && (start_eff != pos);
    end_pos   = dark ? pos : (fwd_eff ? pos - A_ONE : pos + A_ONE);

    line_cur    = NW'(line_eff);
    line_step   = NW'(step);
    last_line_n = NW'(last_line);
    line_new    = cfg.reverse_lines ? line_cur - line_step : line_cur + line_step;
    done        = at_end && (cfg.reverse_lines ? (line_new < $signed(NW'(0)))
                                               : (line_new > last_line_n));

    run_open_nxt  = close ? 1'b0 : (open_eff || dark);
    run_start_nxt = start_eff;
    lls_valid_nxt = lls_valid_eff || cross_en;
    lls_nxt       = cross_en ? line_eff : lls_r;

    along_nxt = pos;
    fwd_nxt   = fwd_eff;
    line_nxt  = line_eff;
    if (at_end) begin
      line_nxt = LW'(line_new);
      if (cfg.serpentine) begin
        along_nxt = fwd_eff ? pos + A_ONE : pos - A_ONE;
        fwd_nxt   = !fwd_eff;
      end else begin
        along_nxt = A_NEG;
        fwd_nxt   = 1'b1;
      end
    end
    hdr_sent_nxt = !done;
  end

  // Build the descriptor for the back end
  always_comb begin
    push_mask                      = '0;
    push_mask[rit_pkg::STEP_HDR_Z] = hdr;
    push_mask[rit_pkg::STEP_HOME]  = hdr;
    push_mask[rit_pkg::STEP_CROSS] = cross_en;
    push_mask[rit_pkg::STEP_START] = close;
    push_mask[rit_pkg::STEP_ZDN]   = close;
    push_mask[rit_pkg::STEP_END]   = end_en;
    push_mask[rit_pkg::STEP_ZUP]   = close;
    push_line  = line_eff;
    push_start = start_eff;
    push_end   = end_pos;
    push       = accept && (push_mask != '0);
  end

  // Advance scan state on each accepted pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_sent_r  <= 1'b0;
      fwd_r       <= 1'b1;
      run_open_r  <= 1'b0;
      lls_valid_r <= 1'b0;
    end else if (accept) begin
      hdr_sent_r  <= hdr_sent_nxt;
      fwd_r       <= fwd_nxt;
      run_open_r  <= run_open_nxt;
      lls_valid_r <= lls_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      along_r     <= along_nxt;
      line_r      <= line_nxt;
      run_start_r <= run_start_nxt;
      lls_r       <= lls_nxt;
    end
  end

  // The first pixel of an image always emits the header
  a_hdr_push: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !hdr_sent_r) |-> push)
    else $error("header pixel did not queue commands");

  // A finished image starts over with a header
  a_done_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && done) |=> !hdr_sent_r)
    else $error("image end did not rearm the header");

endmodule

`default_nettype wire

// ===== hdl/rit_queue.sv =====
// ----------------------------------------------------------------------------
// rit_queue
// Small register FIFO decoupling the pixel front end from command output.
// ----------------------------------------------------------------------------
`default_nettype none

module rit_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rit_pkg::QUEUE_DEPTH_DEF,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  full,
  output logic                  q_valid,
  output logic      [WIDTH-1:0] q_data
);

  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full    = (count_r == CNT_FULL);
  assign q_valid = (count_r != '0);
  assign q_data  = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
    if (push && !pop)      count_nxt = count_r + CW'(1);
    else if (pop && !push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed descriptors
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from an empty queue");

endmodule

`default_nettype wire

// ===== hdl/rit_back.sv =====
// ----------------------------------------------------------------------------
// rit_back
// Command back end: expands queued descriptors into single commands, one per
// cycle while the command channel accepts them, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rit_back #(
  parameter int MAX_DIM = rit_pkg::MAX_DIM_DEF,
  localparam int LW = $clog2(MAX_DIM),
  localparam int AW = LW + 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  rit_pkg::cfg_t      cfg,
  input  wire logic          q_valid,
  input  rit_pkg::step_mask_t q_mask,
  input  wire logic [LW-1:0] q_line,
  input  wire logic [AW-1:0] q_start,
  input  wire logic [AW-1:0] q_end,
  output logic               pop,
  rit_cmd_if.source          out_cmd
);

  rit_pkg::step_mask_t mask_r, mask_nxt;
  logic [LW-1:0]       line_r;
  logic [AW-1:0]       start_r, end_r;

  logic                out_valid_r, out_valid_nxt;
  rit_pkg::cmd_kind_t  kind_r, kind_nxt;
  logic [15:0]         target_r, target_nxt;
  logic                last_r, last_nxt;

  rit_pkg::step_mask_t sel, rest, mask_after;
  logic                can_load, have, emit;
  rit_pkg::cmd_kind_t  along_kind, cross_kind;

  assign out_cmd.valid         = out_valid_r;
  assign out_cmd.command_kind  = kind_r;
  assign out_cmd.target        = target_r;
  assign out_cmd.last_of_pixel = last_r;

  // Pick the next pending step and refill from the queue when done
  always_comb begin
    can_load   = !out_valid_r || out_cmd.ready;
    have       = (mask_r != '0);
    sel        = mask_r & (~mask_r + rit_pkg::step_mask_t'(1));
    rest       = mask_r & ~sel;
    emit       = have && can_load;
    mask_after = emit ? rest : mask_r;
    pop        = q_valid && (mask_after == '0);
    mask_nxt   = pop ? q_mask : mask_after;
  end

  // Decode the selected step into a command
  always_comb begin
    along_kind = cfg.main_axis_x ? rit_pkg::CMD_MOVE_X : rit_pkg::CMD_MOVE_Y;
    cross_kind = cfg.main_axis_x ? rit_pkg::CMD_MOVE_Y : rit_pkg::CMD_MOVE_X;
    kind_nxt   = rit_pkg::CMD_MOVE_Z;
    target_nxt = cfg.z_up;
    priority if (sel[rit_pkg::STEP_HDR_Z]) begin
      kind_nxt   = rit_pkg::CMD_MOVE_Z;
      target_nxt = cfg.z_up;
    end else if (sel[rit_pkg::STEP_HOME]) begin
      kind_nxt   = rit_pkg::CMD_HOME;
      target_nxt = 16'd0;
    end else if (sel[rit_pkg::STEP_CROSS]) begin
      kind_nxt   = cross_kind;
      target_nxt = 16'(line_r);
    end else if (sel[rit_pkg::STEP_START]) begin
      kind_nxt   = along_kind;
      target_nxt = 16'(start_r);
    end else if (sel[rit_pkg::STEP_ZDN]) begin
      kind_nxt   = rit_pkg::CMD_MOVE_Z;
      target_nxt = cfg.z_down;
    end else if (sel[rit_pkg::STEP_END]) begin
      kind_nxt   = along_kind;
      target_nxt = 16'(end_r);
    end else begin
      kind_nxt   = rit_pkg::CMD_MOVE_Z;
      target_nxt = cfg.z_up;
    end
    last_nxt      = (rest == '0);
    out_valid_nxt = can_load ? have : out_valid_r;
  end

  // Hold control state: pending steps and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load descriptor payload and the output command
  always_ff @(posedge clk) begin
    if (pop) begin
      line_r  <= q_line;
      start_r <= q_start;
      end_r   <= q_end;
    end
    if (emit) begin
      kind_r   <= kind_nxt;
      target_r <= target_nxt;
      last_r   <= last_nxt;
    end
  end

  // Every queued descriptor carries at least one command
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (mask_r != '0))
    else $error("empty descriptor loaded");

endmodule

`default_nettype wire

// ===== hdl/raster_image_to_toolpath.sv =====
// ----------------------------------------------------------------------------
// raster_image_to_toolpath
// Converts a scanned RGB raster into tool moves drawing its dark runs.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle in scan order while the descriptor queue
// (QUEUE_DEPTH entries) has room. A pixel that starts an image queues two
// commands ahead of any run it closes, and one that closes a dark run queues
// three to five, so a single pixel queues up to six. The output stage sends
// one command per cycle while the command channel is ready. The input
// stalls only when the queue is full. Configuration is read live and must
// be written only while no commands are pending. No clearing pass.
`default_nettype none

module raster_image_to_toolpath #(
  parameter int MAX_DIM     = rit_pkg::MAX_DIM_DEF,
  parameter int QUEUE_DEPTH = rit_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rit_pixel_if.sink        in_px,
  rit_cmd_if.source        out_cmd,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  localparam int LW = $clog2(MAX_DIM);
  localparam int AW = LW + 2;
  localparam int DW = rit_pkg::NUM_STEPS + LW + 2 * AW;

  rit_pkg::cfg_t       cfg;
  logic                q_full, push, pop, q_valid;
  rit_pkg::step_mask_t push_mask, q_mask;
  logic [LW-1:0]       push_line, q_line;
  logic [AW-1:0]       push_start, push_end, q_start, q_end;
  logic [DW-1:0]       q_data;

  rit_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  rit_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_px      (in_px),
    .q_full     (q_full),
    .push       (push),
    .push_mask  (push_mask),
    .push_line  (push_line),
    .push_start (push_start),
    .push_end   (push_end)
  );

  rit_queue #(.WIDTH(DW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_mask, push_line, push_start, push_end}),
    .pop       (pop),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  assign {q_mask, q_line, q_start, q_end} = q_data;

  rit_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_mask  (q_mask),
    .q_line  (q_line),
    .q_start (q_start),
    .q_end   (q_end),
    .pop     (pop),
    .out_cmd (out_cmd)
  );

endmodule

`default_nettype wire
